// ===== src/utf16_to_utf8_transcoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-16 to UTF-8 transcoder
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_MACROS_SVH

// A property checked on every rising clock edge outside of reset.
`define U2U8_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal that must stay stable in the cycle after a stalled word.
`define U2U8_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
  `U2U8_ASSERT(lbl, clk, rst_n, (vld && !rdy) |=> $stable(sig), msg)

`endif

// ===== src/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared job type, constants and the UTF-8 byte formatting function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2u8_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [20:0] Replacement = 21'h00fffd;
  localparam logic [15:0] HighFirst   = 16'hd800;
  localparam logic [15:0] HighLast    = 16'hdbff;
  localparam logic [15:0] LowFirst    = 16'hdc00;
  localparam logic [15:0] LowLast     = 16'hdfff;
  localparam logic [20:0] SuppBase    = 21'h010000;

  // Index of the last byte of a sequence: length minus one.
  localparam logic [1:0] LastIdx1 = 2'd0;
  localparam logic [1:0] LastIdx2 = 2'd1;
  localparam logic [1:0] LastIdx3 = 2'd2;
  localparam logic [1:0] LastIdx4 = 2'd3;

  // One unit of work for the byte emitter: an optional replacement character
  // followed by an optional code point.
  typedef struct packed {
    logic        pre_rep;
    logic        has_main;
    logic [1:0]  last_idx;
    logic [20:0] cp;
  } job_t;

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                           input logic [1:0]  last_idx,
                                           input logic [1:0]  idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (last_idx)
      LastIdx1: b = {1'b0, cp[6:0]};
      LastIdx2: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      LastIdx3: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// ===== src/u2u8_if.sv =====
// ----------------------------------------------------------------------------
// Transcoder stream interfaces
// Valid/ready channels for UTF-16 code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       run_end;

  modport source (output valid, output data_byte, output run_end, input ready);
  modport sink (input valid, input data_byte, input run_end, output ready);
endinterface

// ===== src/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts code units, pairs surrogates and queues one job per word that
// produces output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u8_front import u2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2u8_in_if.sink    in_i,
  input  logic       job_ready_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  logic       pending_q, pending_d;
  logic [9:0] held_q, held_d;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       bmp_len2;
  logic       bmp_len1;

  assign in_i.ready = job_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_high    = (in_i.code_unit >= HighFirst) && (in_i.code_unit <= HighLast);
  assign is_low     = (in_i.code_unit >= LowFirst) && (in_i.code_unit <= LowLast);
  assign bmp_len1   = (in_i.code_unit[15:7] == 9'd0);
  assign bmp_len2   = (in_i.code_unit[15:11] == 5'd0);

  always_comb begin
    job_o     = '0;
    pending_d = pending_q;
    held_d    = held_q;
    if (pending_q && is_low) begin
      job_o.has_main = 1'b1;
      job_o.last_idx = LastIdx4;
      job_o.cp       = SuppBase + {1'b0, held_q, in_i.code_unit[9:0]};
      pending_d      = 1'b0;
      held_d         = '0;
    end else begin
      // A held high surrogate that is not followed by a low one is replaced.
      job_o.pre_rep = pending_q;
      pending_d     = 1'b0;
      held_d        = '0;
      if (is_high && !in_i.last_unit) begin
        pending_d = 1'b1;
        held_d    = in_i.code_unit[9:0];
      end else if (is_high || is_low) begin
        job_o.has_main = 1'b1;
        job_o.last_idx = LastIdx3;
        job_o.cp       = Replacement;
      end else begin
        job_o.has_main = 1'b1;
        job_o.cp       = {5'd0, in_i.code_unit};
        if (bmp_len1) begin
          job_o.last_idx = LastIdx1;
        end else if (bmp_len2) begin
          job_o.last_idx = LastIdx2;
        end else begin
          job_o.last_idx = LastIdx3;
        end
      end
    end
  end

  assign job_valid_o = accept && (job_o.pre_rep || job_o.has_main);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= '0;
    end else if (accept) begin
      pending_q <= pending_d;
      held_q    <= held_d;
    end
  end

endmodule

// ===== src/u2u8_fifo.sv =====
// ----------------------------------------------------------------------------
// Transcoder job queue
// Short first-in first-out buffer between the front end and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u8_fifo import u2u8_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic push_ready_o,
  input  logic pop_i,
  output logic pop_valid_o,
  output job_t pop_job_o
);

  job_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoCntW-1:0] count_q;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (count_q != FifoCntW'(FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// Transcoder byte emitter
// Walks each queued job and sends its UTF-8 bytes through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u8_back import u2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  u2u8_out_if.source out_o
);

  logic       busy_q;
  job_t       job_q;
  logic       in_pre_q;
  logic [1:0] idx_q;
  logic       ov_q;
  logic [7:0] ob_q;
  logic       oe_q;

  logic       load;
  logic       emit;
  logic       pre_done;
  logic       main_done;
  logic       job_last;
  logic [7:0] cur_byte;

  assign load      = !ov_q || out_o.ready;
  assign emit      = busy_q && load;
  assign pre_done  = in_pre_q && (idx_q == LastIdx3);
  assign main_done = !in_pre_q && (idx_q == job_q.last_idx);
  assign job_last  = main_done || (pre_done && !job_q.has_main);
  assign cur_byte  = in_pre_q ? utf8_byte(Replacement, LastIdx3, idx_q)
                              : utf8_byte(job_q.cp, job_q.last_idx, idx_q);

  // The next job is taken in the cycle that sends the last byte of this one.
  assign job_pop_o = job_valid_i && (!busy_q || (emit && job_last));

  assign out_o.valid     = ov_q;
  assign out_o.data_byte = ob_q;
  assign out_o.run_end   = oe_q;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      ob_q <= cur_byte;
      oe_q <= job_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      in_pre_q <= 1'b0;
      idx_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (job_pop_o) begin
        busy_q   <= 1'b1;
        in_pre_q <= job_i.pre_rep;
        idx_q    <= '0;
      end else if (emit && job_last) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        if (pre_done) begin
          in_pre_q <= 1'b0;
          idx_q    <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end

      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule

// ===== src/utf16_to_utf8_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Each word's job goes through the job queue and the emitter's job register;
// its bytes then leave the output register, one per cycle while the output
// is ready: 1 to 4 bytes, plus 3 for a replaced unpaired high surrogate.
// Reset clears the held surrogate, the job queue and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_top import u2u8_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2u8_in_if.sink    in_i,
  u2u8_out_if.source out_o
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop;
  job_t pop_job;

  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_ready_i (push_ready),
    .job_valid_o (push_valid),
    .job_o       (push_job)
  );

  u2u8_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job)
  );

  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_o       (out_o)
  );

endmodule

// ===== src/u2u8_checker.sv =====
// ----------------------------------------------------------------------------
// Transcoder port checker
// Watches the output channel of the transcoder over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_top_macros.svh"

module u2u8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] data_byte_i,
  input logic       out_run_end_i
);

  `U2U8_ASSERT_HOLD(a_valid_held, clk_i, rst_ni, out_valid_i, out_ready_i,
                    out_valid_i, "stalled word dropped")
  `U2U8_ASSERT_HOLD(a_byte_held, clk_i, rst_ni, out_valid_i, out_ready_i,
                    data_byte_i, "stalled byte changed")
  // An ASCII byte is always a whole sequence and ends its word's output.
  `U2U8_ASSERT(a_ascii_ends, clk_i, rst_ni,
               (out_valid_i && !data_byte_i[7]) |-> out_run_end_i,
               "ASCII byte without run end")
  // A four-byte lead is always followed by its continuation bytes.
  `U2U8_ASSERT(a_lead4_open, clk_i, rst_ni,
               (out_valid_i && (data_byte_i[7:3] == 5'b11110)) |-> !out_run_end_i,
               "run end on lead byte")

endmodule

bind utf16_to_utf8_transcoder_top u2u8_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .data_byte_i   (out_o.data_byte),
  .out_run_end_i (out_o.run_end)
);
